[rtl/core/segmented_prime_sieve_core_defines.svh]
// Assertion macros shared by the segmented prime sieve RTL.
`ifndef SEGMENTED_PRIME_SIEVE_CORE_DEFINES_SVH
`define SEGMENTED_PRIME_SIEVE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define SPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk.
`define SPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/sps_pkg.sv]
// Types, codes and constants shared by the segmented prime sieve modules.
package sps_pkg;

   localparam int unsigned SEGMENT_BITS_DEFAULT = 4096;
   localparam int unsigned WORD_BITS            = 64;

   // Action field codes of a request.
   localparam logic [1:0] ACTION_CLEAR = 2'd0;
   localparam logic [1:0] ACTION_MARK  = 2'd1;
   localparam logic [1:0] ACTION_READ  = 2'd2;

   // Internal operation codes after classification.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_MARK  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SEGMENT_START = 2'd0;
   localparam logic [1:0] CSR_SEGMENT_END   = 2'd1;
   localparam logic [1:0] CSR_PRIME_LIMIT   = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] sieve_prime;
      logic [5:0]  word_index;
   } req_type;

   typedef struct packed {
      logic [15:0] next_prime;
      logic        done_res;
      logic [63:0] prime_flags;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        skip_mark;
      logic [15:0] sieve_prime;
      logic [5:0]  word_index;
      logic [31:0] prime_sq;
      logic [16:0] step;
   } cmd_type;

   typedef struct packed {
      logic [31:0] segment_start;
      logic [15:0] prime_limit;
   } cfg_type;

endpackage

[rtl/core/sps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sps_ram #(
   parameter int unsigned WIDTH = sps_pkg::WORD_BITS,
   parameter int unsigned DEPTH = sps_pkg::SEGMENT_BITS_DEFAULT / sps_pkg::WORD_BITS
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/sps_front.sv]
// Front stage: accepts requests, classifies them and precomputes p squared and the step.
module sps_front #(
   parameter int unsigned SEGMENT_BITS = sps_pkg::SEGMENT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             req_valid,
   output logic             req_ready,
   input  sps_pkg::req_type req_data,
   input  logic             q_ready,
   output logic             q_push,
   output sps_pkg::cmd_type q_cmd
);

   localparam int unsigned STORE_WORDS = SEGMENT_BITS / sps_pkg::WORD_BITS;

   logic             valid_ff, valid_in;
   sps_pkg::cmd_type cmd_ff, cmd_in;
   logic             accept;

   assign req_ready = enable && (!valid_ff || q_ready);
   assign accept    = req_valid && req_ready;
   assign q_push    = valid_ff;
   assign q_cmd     = cmd_ff;

   always_comb begin
      cmd_in             = cmd_ff;
      cmd_in.sieve_prime = req_data.sieve_prime;
      cmd_in.word_index  = req_data.word_index;
      cmd_in.skip_mark   = (req_data.sieve_prime < 16'd2);
      cmd_in.prime_sq    = 32'(req_data.sieve_prime) * 32'(req_data.sieve_prime);
      cmd_in.step        = (req_data.sieve_prime == 16'd2) ? 17'd2
                                                           : {req_data.sieve_prime, 1'b0};
      unique case (req_data.action)
         sps_pkg::ACTION_CLEAR: cmd_in.op = sps_pkg::OP_CLEAR;
         sps_pkg::ACTION_MARK:  cmd_in.op = sps_pkg::OP_MARK;
         sps_pkg::ACTION_READ: begin
            // A word past the end of the store reads as all zeros.
            cmd_in.op = (32'(req_data.word_index) >= 32'(STORE_WORDS)) ? sps_pkg::OP_NONE
                                                                       : sps_pkg::OP_READ;
         end
         default:               cmd_in.op = sps_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

[rtl/core/sps_queue.sv]
// Two-entry command queue between the front and back stages.
module sps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  sps_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output sps_pkg::cmd_type pop_data
);

   localparam int unsigned DEPTH = 2;

   sps_pkg::cmd_type entry_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/sps_back.sv]
// Back stage: clears, marks, searches and reads the composite-mark store.
module sps_back #(
   parameter int unsigned SEGMENT_BITS = sps_pkg::SEGMENT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  sps_pkg::cmd_type                    q_cmd,
   input  sps_pkg::cfg_type                    cfg,
   input  logic [$clog2(SEGMENT_BITS+1)-1:0]   seg_len,
   output logic                                init_busy,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sps_pkg::rsp_type                    rsp_data
);

   localparam int unsigned STORE_WORDS = SEGMENT_BITS / sps_pkg::WORD_BITS;
   localparam int unsigned WA = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int unsigned LW = $clog2(SEGMENT_BITS + 1);
   localparam int unsigned MW = ((LW > 17) ? LW : 17) + 1;
   localparam int unsigned KW = (LW > 12) ? LW : 12;

   localparam logic [3:0] ST_INIT      = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_CLEAR     = 4'd2;
   localparam logic [3:0] ST_DIV       = 4'd3;
   localparam logic [3:0] ST_SET_DIFF  = 4'd4;
   localparam logic [3:0] ST_SET_MAX   = 4'd5;
   localparam logic [3:0] ST_SET_ODD   = 4'd6;
   localparam logic [3:0] ST_SET_CHK   = 4'd7;
   localparam logic [3:0] ST_MARK_RD   = 4'd8;
   localparam logic [3:0] ST_MARK_LOAD = 4'd9;
   localparam logic [3:0] ST_MARK_ACC  = 4'd10;
   localparam logic [3:0] ST_SRCH      = 4'd11;
   localparam logic [3:0] ST_SRCH_LOAD = 4'd12;
   localparam logic [3:0] ST_READ_RD   = 4'd13;
   localparam logic [3:0] ST_READ_LOAD = 4'd14;
   localparam logic [3:0] ST_RESULT    = 4'd15;

   logic [3:0]       state_ff, state_in;
   sps_pkg::cmd_type cmd_ff, cmd_in;
   logic [WA-1:0]    clr_ff, clr_in;
   logic [15:0]      rem_ff, rem_in;
   logic [4:0]       div_cnt_ff, div_cnt_in;
   logic [32:0]      diff_ff, diff_in;
   logic [33:0]      off_w_ff, off_w_in;
   logic [MW-1:0]    mark_off_ff, mark_off_in;
   logic [WA-1:0]    cur_word_ff, cur_word_in;
   logic [63:0]      word_ff, word_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [16:0]      v_ff, v_in;
   sps_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sps_pkg::rsp_type rsp_data_ff;

   logic             ram_we;
   logic [WA-1:0]    ram_waddr, ram_raddr;
   logic [63:0]      ram_wdata, ram_rdata;

   logic             out_free;
   logic [16:0]      rem_shift;
   logic [15:0]      delta;
   logic [16:0]      first_cand;
   logic             mark_in_range, mark_same_word;
   logic [32:0]      sdiff;
   logic             s_outside, s_over;
   logic [WA-1:0]    s_word;
   logic [63:0]      read_mask, read_flags;

   sps_ram #(
      .WIDTH(sps_pkg::WORD_BITS),
      .DEPTH(STORE_WORDS)
   ) u_marks (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_busy = (state_ff == ST_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // One restoring-division step per cycle for segment_start mod p.
   assign rem_shift = {rem_ff, cfg.segment_start[5'd31 - div_cnt_ff]};
   assign delta     = (rem_ff == 16'd0) ? 16'd0 : cmd_ff.sieve_prime - rem_ff;

   always_comb begin
      first_cand = q_cmd.sieve_prime[0] ? {1'b0, q_cmd.sieve_prime} + 17'd2
                                        : {1'b0, q_cmd.sieve_prime} + 17'd1;
      if (first_cand < 17'd3) begin
         first_cand = 17'd3;
      end
   end

   assign mark_in_range  = (mark_off_ff < MW'(seg_len));
   assign mark_same_word = (mark_off_ff[MW-1:6] == (MW-6)'(cur_word_ff));

   // Candidates outside the covered segment count as unmarked.
   assign sdiff     = {16'd0, v_ff} - {1'b0, cfg.segment_start};
   assign s_outside = sdiff[32] || (sdiff[31:0] >= 32'(seg_len));
   assign s_over    = (v_ff > {1'b0, cfg.prime_limit});
   assign s_word    = sdiff[WA+5:6];

   always_comb begin
      for (int i = 0; i < 64; i++) begin
         read_mask[i] = (KW'({cmd_ff.word_index, 6'(i)}) < KW'(seg_len));
      end
      // Values 0 and 1 are never prime.
      if (cmd_ff.word_index == 6'd0) begin
         if (cfg.segment_start == 32'd0) begin
            read_mask[1:0] = 2'b00;
         end else if (cfg.segment_start == 32'd1) begin
            read_mask[0] = 1'b0;
         end
      end
      read_flags = ~ram_rdata & read_mask;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      clr_in       = clr_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      diff_in      = diff_ff;
      off_w_in     = off_w_ff;
      mark_off_in  = mark_off_ff;
      cur_word_in  = cur_word_ff;
      word_in      = word_ff;
      cur_valid_in = cur_valid_ff;
      v_in         = v_ff;
      res_in       = res_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == WA'(STORE_WORDS - 1)) begin
               clr_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_RESULT;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               cmd_in       = q_cmd;
               res_in       = '0;
               cur_valid_in = 1'b0;
               rem_in       = '0;
               div_cnt_in   = '0;
               v_in         = first_cand;
               unique case (q_cmd.op)
                  sps_pkg::OP_CLEAR: state_in = ST_CLEAR;
                  sps_pkg::OP_MARK:  state_in = q_cmd.skip_mark ? ST_SRCH : ST_DIV;
                  sps_pkg::OP_READ:  state_in = ST_READ_RD;
                  sps_pkg::OP_NONE:  state_in = ST_RESULT;
               endcase
            end
         end
         ST_DIV: begin
            rem_in = (rem_shift >= {1'b0, cmd_ff.sieve_prime})
                     ? 16'(rem_shift - {1'b0, cmd_ff.sieve_prime}) : rem_shift[15:0];
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               state_in = ST_SET_DIFF;
            end
         end
         ST_SET_DIFF: begin
            diff_in  = {1'b0, cmd_ff.prime_sq} - {1'b0, cfg.segment_start};
            state_in = ST_SET_MAX;
         end
         ST_SET_MAX: begin
            // First offset: the larger of p squared and the first multiple in the segment.
            off_w_in = (!diff_ff[32] && (diff_ff[31:0] > {16'd0, delta}))
                       ? {2'b00, diff_ff[31:0]} : {18'd0, delta};
            state_in = ST_SET_ODD;
         end
         ST_SET_ODD: begin
            // Odd primes visit odd multiples only.
            if ((cmd_ff.sieve_prime != 16'd2) && !(cfg.segment_start[0] ^ off_w_ff[0])) begin
               off_w_in = off_w_ff + {18'd0, cmd_ff.sieve_prime};
            end
            state_in = ST_SET_CHK;
         end
         ST_SET_CHK: begin
            if (off_w_ff < 34'(seg_len)) begin
               mark_off_in = MW'(off_w_ff);
               state_in    = ST_MARK_RD;
            end else begin
               state_in = ST_SRCH;
            end
         end
         ST_MARK_RD: begin
            ram_raddr   = mark_off_ff[WA+5:6];
            cur_word_in = mark_off_ff[WA+5:6];
            state_in    = ST_MARK_LOAD;
         end
         ST_MARK_LOAD: begin
            word_in  = ram_rdata;
            state_in = ST_MARK_ACC;
         end
         ST_MARK_ACC: begin
            if (mark_in_range && mark_same_word) begin
               word_in     = word_ff | (64'd1 << mark_off_ff[5:0]);
               mark_off_in = mark_off_ff + MW'(cmd_ff.step);
            end else begin
               ram_we    = 1'b1;
               ram_waddr = cur_word_ff;
               ram_wdata = word_ff;
               state_in  = mark_in_range ? ST_MARK_RD : ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (s_over) begin
               res_in.done_res = 1'b1;
               state_in        = ST_RESULT;
            end else if (s_outside) begin
               res_in.next_prime = v_ff[15:0];
               state_in          = ST_RESULT;
            end else if (cur_valid_ff && (s_word == cur_word_ff)) begin
               if (!word_ff[sdiff[5:0]]) begin
                  res_in.next_prime = v_ff[15:0];
                  state_in          = ST_RESULT;
               end else begin
                  v_in = v_ff + 17'd2;
               end
            end else begin
               ram_raddr   = s_word;
               cur_word_in = s_word;
               state_in    = ST_SRCH_LOAD;
            end
         end
         ST_SRCH_LOAD: begin
            word_in      = ram_rdata;
            cur_valid_in = 1'b1;
            state_in     = ST_SRCH;
         end
         ST_READ_RD: begin
            ram_raddr = WA'(cmd_ff.word_index);
            state_in  = ST_READ_LOAD;
         end
         ST_READ_LOAD: begin
            res_in.prime_flags = read_flags;
            state_in           = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_RESULT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      diff_ff      <= diff_in;
      off_w_ff     <= off_w_in;
      mark_off_ff  <= mark_off_in;
      cur_word_ff  <= cur_word_in;
      word_ff      <= word_in;
      cur_valid_ff <= cur_valid_in;
      v_ff         <= v_in;
      res_ff       <= res_in;
      if ((state_ff == ST_RESULT) && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

endmodule

[rtl/core/segmented_prime_sieve_core.sv]
// Segmented prime sieve: top level with configuration registers, front, queue and back.
//
// Requests arrive on the req_ channel (valid/ready); every transaction gives exactly one
// result on the rsp_ channel. Configuration registers are written through csr_we,
// csr_index and csr_wdata; the user must write them only while the block is idle,
// and the block itself does not enforce this. A clear sweeps every store word in the
// back stage, and a read fetches one word. A mark runs the restoring remainder divider,
// then the setup states, then the read-modify-write path of the mark store for each
// store word that holds marked multiples; the search then steps over odd candidates
// and fetches store words as needed. Items are worked one at a time in the back stage.
// After reset the store is swept to zero with req_ready low. Results wait in an
// output register when the receiver stalls; the back stage then holds its next
// result, while the front register and a two-entry queue keep taking requests.
module segmented_prime_sieve_core #(
   parameter int unsigned SEGMENT_BITS = sps_pkg::SEGMENT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sps_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   `include "segmented_prime_sieve_core_defines.svh"

   localparam int unsigned LW = $clog2(SEGMENT_BITS + 1);

   logic [31:0]      seg_start_ff, seg_start_in;
   logic [31:0]      seg_end_ff, seg_end_in;
   logic [15:0]      prime_limit_ff, prime_limit_in;
   logic [LW-1:0]    seg_len_ff, seg_len_in;
   logic [31:0]      seg_span;
   sps_pkg::cfg_type cfg;

   logic             init_busy;
   logic             q_push, q_ready, q_valid, q_pop;
   sps_pkg::cmd_type push_cmd, pop_cmd;

   always_comb begin
      seg_start_in   = seg_start_ff;
      seg_end_in     = seg_end_ff;
      prime_limit_in = prime_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            sps_pkg::CSR_SEGMENT_START: seg_start_in   = csr_wdata;
            sps_pkg::CSR_SEGMENT_END:   seg_end_in     = csr_wdata;
            sps_pkg::CSR_PRIME_LIMIT:   prime_limit_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Segment length, capped at the store size and zero for an empty segment.
   assign seg_span = seg_end_ff - seg_start_ff;

   always_comb begin
      if (seg_end_ff < seg_start_ff) begin
         seg_len_in = '0;
      end else if (seg_span >= 32'(SEGMENT_BITS)) begin
         seg_len_in = LW'(SEGMENT_BITS);
      end else begin
         seg_len_in = LW'(seg_span + 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_start_ff   <= 32'd1;
         seg_end_ff     <= 32'd4096;
         prime_limit_ff <= 16'd64;
      end else begin
         seg_start_ff   <= seg_start_in;
         seg_end_ff     <= seg_end_in;
         prime_limit_ff <= prime_limit_in;
      end
      seg_len_ff <= seg_len_in;
   end

   assign cfg.segment_start = seg_start_ff;
   assign cfg.prime_limit   = prime_limit_ff;

   sps_front #(
      .SEGMENT_BITS(SEGMENT_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (!init_busy),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   sps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(q_push),
      .push_ready(q_ready),
      .push_data (push_cmd),
      .pop_valid (q_valid),
      .pop_ready (q_pop),
      .pop_data  (pop_cmd)
   );

   sps_back #(
      .SEGMENT_BITS(SEGMENT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_cmd    (pop_cmd),
      .cfg      (cfg),
      .seg_len  (seg_len_ff),
      .init_busy(init_busy),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   `SPS_ASSERT_NXT(a_reset_starts_sweep, clock, 1'b0, reset, init_busy,
                   "no clearing pass after reset")
   `SPS_ASSERT_IMP(a_sweep_blocks_io, clock, reset, init_busy, !req_ready && !rsp_valid,
                   "traffic during clearing pass")
   `SPS_ASSERT_IMP(a_pop_has_data, clock, reset, q_pop, q_valid, "back stage popped an empty queue")

endmodule

[tb/segmented_prime_sieve_core_tb.sv]
// Self-checking testbench for the segmented prime sieve core.
`timescale 1ns / 1ps

module segmented_prime_sieve_core_tb;

   localparam int unsigned SEG_BITS      = sps_pkg::SEGMENT_BITS_DEFAULT;
   localparam int unsigned STORE_WORDS   = SEG_BITS / sps_pkg::WORD_BITS;
   localparam logic [1:0]  ACTION_UNUSED = 2'd3;
   localparam logic [1:0]  CSR_UNUSED    = 2'd3;
   localparam int          RANDOM_ITEMS  = 260;

   typedef struct packed {
      logic             is_csr;
      logic [1:0]       csr_idx;
      logic [31:0]      csr_val;
      sps_pkg::req_type item;
      logic             has_lit;
      sps_pkg::rsp_type lit;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sps_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sps_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [31:0]      csr_wdata = '0;

   // Shadow copy of the block's mark store and registers.
   logic [63:0] comp_bits [STORE_WORDS];
   logic [31:0] seg_first;
   logic [31:0] seg_last;
   logic [15:0] cand_limit;

   sps_pkg::rsp_type results_due [$];
   stim_row_type     stim_table [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int items_sent = 0;
   int results_checked = 0;
   int marks_sent = 0;
   int reads_sent = 0;
   int clears_sent = 0;
   int csr_writes = 0;

   segmented_prime_sieve_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit [63:0] covered_len();
      bit [63:0] n;
      if (seg_last < seg_first) return 64'd0;
      n = {32'd0, seg_last} - {32'd0, seg_first} + 64'd1;
      if (n > 64'(SEG_BITS)) n = 64'(SEG_BITS);
      return n;
   endfunction

   function automatic logic is_struck(bit [63:0] off);
      return comp_bits[(off >> 6) % STORE_WORDS][off[5:0]];
   endfunction

   // Applies one transaction to the shadow state and returns its result.
   function automatic sps_pkg::rsp_type sieve_step(sps_pkg::req_type item);
      sps_pkg::rsp_type r;
      bit [63:0]        len, first, last, p, m, rem, step, off, v, w;
      bit               found;
      int               i;
      r = '0;
      len = covered_len();
      first = {32'd0, seg_first};
      case (item.action)
         sps_pkg::ACTION_CLEAR: begin
            foreach (comp_bits[k]) comp_bits[k] = '0;
         end
         sps_pkg::ACTION_MARK: begin
            p = {48'd0, item.sieve_prime};
            if (p >= 2 && len != 0) begin
               last = first + len - 1;
               rem = first % p;
               m = (rem == 0) ? first : first + (p - rem);
               if (p * p > m) m = p * p;
               step = p;
               // Odd primes only need their odd multiples.
               if (p != 2) begin
                  if (!m[0]) m += p;
                  step = 2 * p;
               end
               while (m <= last) begin
                  off = m - first;
                  comp_bits[(off >> 6) % STORE_WORDS][off[5:0]] = 1'b1;
                  m += step;
               end
            end
            v = p + 1;
            if (!v[0]) v += 1;
            if (v < 3) v = 3;
            found = 1'b0;
            while (!found && v <= {48'd0, cand_limit}) begin
               if (v < first || v - first >= len || !is_struck(v - first)) found = 1'b1;
               else v += 2;
            end
            if (found) r.next_prime = v[15:0];
            else r.done_res = 1'b1;
         end
         sps_pkg::ACTION_READ: begin
            w = {58'd0, item.word_index};
            if (w < 64'(STORE_WORDS)) begin
               for (i = 0; i < 64; i++) begin
                  off = 64 * w + 64'(i);
                  v = first + off;
                  if (off < len && v > 1 && !is_struck(off)) r.prime_flags[i] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic stim_row_type req_row(logic [1:0] act, logic [15:0] prime,
                                            logic [5:0] word);
      stim_row_type r;
      r = '0;
      r.item.action = act;
      r.item.sieve_prime = prime;
      r.item.word_index = word;
      return r;
   endfunction

   function automatic stim_row_type lit_row(logic [1:0] act, logic [15:0] prime,
                                            logic [5:0] word, logic [15:0] nxt,
                                            logic done, logic [63:0] flags);
      stim_row_type r;
      r = req_row(act, prime, word);
      r.has_lit = 1'b1;
      r.lit.next_prime = nxt;
      r.lit.done_res = done;
      r.lit.prime_flags = flags;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [1:0] idx, logic [31:0] val);
      stim_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   function automatic sps_pkg::req_type random_item();
      sps_pkg::req_type item;
      item.action = 2'($urandom_range(3));
      if ($urandom_range(1)) item.sieve_prime = 16'($urandom_range(65535));
      else item.sieve_prime = 16'($urandom_range(40));
      item.word_index = 6'($urandom_range(63));
      return item;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want_v);
      if (mismatches < 40)
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want_v);
      mismatches++;
   endtask

   task automatic send_req(input sps_pkg::req_type item, input logic has_lit,
                           input sps_pkg::rsp_type lit, output sps_pkg::rsp_type pred);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      pred = sieve_step(item);
      results_due.push_back(has_lit ? lit : pred);
      items_sent++;
      case (item.action)
         sps_pkg::ACTION_CLEAR: clears_sent++;
         sps_pkg::ACTION_MARK:  marks_sent++;
         sps_pkg::ACTION_READ:  reads_sent++;
         default: ;
      endcase
   endtask

   // Holds the sender off until every outstanding transaction has answered.
   task automatic wait_results_in();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         sps_pkg::CSR_SEGMENT_START: seg_first = val;
         sps_pkg::CSR_SEGMENT_END:   seg_last = val;
         sps_pkg::CSR_PRIME_LIMIT:   cand_limit = val[15:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   always @(negedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : check_results
      sps_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch("result with no transaction outstanding",
                            rsp_data.prime_flags, 64'd0);
         end else begin
            want = results_due.pop_front();
            results_checked++;
            if (rsp_data.next_prime !== want.next_prime)
               report_mismatch("next_prime", 64'(rsp_data.next_prime), 64'(want.next_prime));
            if (rsp_data.done_res !== want.done_res)
               report_mismatch("done_res", 64'(rsp_data.done_res), 64'(want.done_res));
            if (rsp_data.prime_flags !== want.prime_flags)
               report_mismatch("prime_flags", rsp_data.prime_flags, want.prime_flags);
         end
      end
   end

   initial begin
      #100_000_000;
      $display("timeout with %0d results outstanding", results_due.size());
      $display("FAIL segmented_prime_sieve_core");
      $finish;
   end

   initial begin
      sps_pkg::rsp_type pred;
      sps_pkg::req_type item;
      logic [31:0]      s_first, s_last;
      logic [15:0]      lim, p;
      bit [63:0]        len, w_top;
      int               sel, n_marks, n_reads, round, guard, directed_items;

      foreach (comp_bits[k]) comp_bits[k] = '0;
      seg_first = 32'd1;
      seg_last = 32'd4096;
      cand_limit = 16'd64;

      // Reset segment covers 1..4096 with a limit of 64.
      stim_table.push_back(lit_row(sps_pkg::ACTION_READ, 16'd0, 6'd0, 16'd0, 1'b0,
                                   64'hFFFF_FFFF_FFFF_FFFE));
      stim_table.push_back(lit_row(sps_pkg::ACTION_READ, 16'd0, 6'd63, 16'd0, 1'b0, '1));
      stim_table.push_back(lit_row(ACTION_UNUSED, 16'hFFFF, 6'd63, 16'd0, 1'b0, '0));
      stim_table.push_back(lit_row(sps_pkg::ACTION_MARK, 16'd0, 6'd0, 16'd3, 1'b0, '0));
      stim_table.push_back(lit_row(sps_pkg::ACTION_MARK, 16'd1, 6'd0, 16'd3, 1'b0, '0));
      stim_table.push_back(lit_row(sps_pkg::ACTION_MARK, 16'hFFFF, 6'd63, 16'd0, 1'b1, '0));
      stim_table.push_back(req_row(sps_pkg::ACTION_MARK, 16'd2, 6'd0));
      stim_table.push_back(req_row(sps_pkg::ACTION_MARK, 16'd3, 6'd0));
      stim_table.push_back(req_row(sps_pkg::ACTION_MARK, 16'd5, 6'd0));
      stim_table.push_back(req_row(sps_pkg::ACTION_READ, 16'd0, 6'd0));
      stim_table.push_back(req_row(sps_pkg::ACTION_READ, 16'd0, 6'd1));
      stim_table.push_back(lit_row(sps_pkg::ACTION_CLEAR, 16'hFFFF, 6'd63, 16'd0, 1'b0, '0));
      stim_table.push_back(lit_row(sps_pkg::ACTION_READ, 16'd0, 6'd0, 16'd0, 1'b0,
                                   64'hFFFF_FFFF_FFFF_FFFE));
      // A limit of zero leaves no candidate; upper data bits must be dropped.
      stim_table.push_back(csr_row(sps_pkg::CSR_PRIME_LIMIT, 32'hABCD_0000));
      stim_table.push_back(lit_row(sps_pkg::ACTION_MARK, 16'd2, 6'd0, 16'd0, 1'b1, '0));
      stim_table.push_back(req_row(sps_pkg::ACTION_READ, 16'd0, 6'd0));
      stim_table.push_back(csr_row(CSR_UNUSED, 32'h0000_0007));
      stim_table.push_back(csr_row(sps_pkg::CSR_PRIME_LIMIT, 32'h5A5A_FFFF));
      stim_table.push_back(req_row(sps_pkg::ACTION_MARK, 16'd3, 6'd0));
      // Segment far longer than the store saturates at its size.
      stim_table.push_back(csr_row(sps_pkg::CSR_SEGMENT_START, 32'd0));
      stim_table.push_back(csr_row(sps_pkg::CSR_SEGMENT_END, 32'hFFFF_FFFF));
      stim_table.push_back(lit_row(sps_pkg::ACTION_CLEAR, 16'd0, 6'd0, 16'd0, 1'b0, '0));
      stim_table.push_back(lit_row(sps_pkg::ACTION_READ, 16'd0, 6'd0, 16'd0, 1'b0,
                                   64'hFFFF_FFFF_FFFF_FFFC));
      stim_table.push_back(req_row(sps_pkg::ACTION_MARK, 16'd2, 6'd0));
      stim_table.push_back(req_row(sps_pkg::ACTION_READ, 16'd0, 6'd0));
      // Empty segment: end below start.
      stim_table.push_back(csr_row(sps_pkg::CSR_SEGMENT_START, 32'hFFFF_FFFF));
      stim_table.push_back(csr_row(sps_pkg::CSR_SEGMENT_END, 32'd5));
      stim_table.push_back(lit_row(sps_pkg::ACTION_READ, 16'd0, 6'd0, 16'd0, 1'b0, '0));
      stim_table.push_back(lit_row(sps_pkg::ACTION_MARK, 16'd2, 6'd0, 16'd3, 1'b0, '0));
      // One-value segment whose start is itself a multiple of the prime.
      stim_table.push_back(csr_row(sps_pkg::CSR_SEGMENT_END, 32'hFFFF_FFFF));
      stim_table.push_back(req_row(sps_pkg::ACTION_READ, 16'd0, 6'd0));
      stim_table.push_back(req_row(sps_pkg::ACTION_MARK, 16'hFFFF, 6'd0));
      stim_table.push_back(req_row(sps_pkg::ACTION_READ, 16'd0, 6'd0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[r]) begin
         if (stim_table[r].is_csr) begin
            wait_results_in();
            write_csr(stim_table[r].csr_idx, stim_table[r].csr_val);
         end else begin
            send_req(stim_table[r].item, stim_table[r].has_lit, stim_table[r].lit, pred);
         end
      end
      directed_items = items_sent;

      round = 0;
      while (items_sent - directed_items < RANDOM_ITEMS) begin
         case (round % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         wait_results_in();

         sel = $urandom_range(9);
         if (sel <= 5) begin
            s_first = $urandom_range(1, 3000);
            s_last = s_first + $urandom_range(0, 400);
         end else if (sel <= 7) begin
            s_first = $urandom_range(1, 4);
            s_last = s_first + $urandom_range(400, 4095);
         end else if (sel == 8) begin
            s_first = $urandom;
            s_last = $urandom;
         end else begin
            s_first = $urandom_range(0, 2);
            s_last = 32'hFFFF_FFFF;
         end
         sel = $urandom_range(9);
         if (sel <= 6) lim = 16'($urandom_range(2, 120));
         else if (sel == 7) lim = 16'($urandom_range(1));
         else if (sel == 8) lim = 16'hFFFF;
         else lim = 16'($urandom_range(65535));
         write_csr(sps_pkg::CSR_SEGMENT_START, s_first);
         write_csr(sps_pkg::CSR_SEGMENT_END, s_last);
         write_csr(sps_pkg::CSR_PRIME_LIMIT, {16'($urandom_range(65535)), lim});
         if ($urandom_range(5) == 0) write_csr(CSR_UNUSED, $urandom);

         // A well-formed sieve pass: clear, then walk the primes it reports.
         item = '0;
         item.action = sps_pkg::ACTION_CLEAR;
         item.word_index = 6'($urandom_range(63));
         send_req(item, 1'b0, '0, pred);
         p = 16'd2;
         n_marks = $urandom_range(3, 14);
         for (int j = 0; j < n_marks; j++) begin
            if ($urandom_range(9) < 2) send_req(random_item(), 1'b0, '0, pred);
            item.action = sps_pkg::ACTION_MARK;
            item.sieve_prime = p;
            item.word_index = 6'($urandom_range(63));
            send_req(item, 1'b0, '0, pred);
            if (pred.done_res) break;
            p = pred.next_prime;
         end

         len = covered_len();
         w_top = (len == 0) ? 64'd0 : (len - 1) / 64;
         n_reads = $urandom_range(2, 6);
         for (int j = 0; j < n_reads; j++) begin
            item = '0;
            item.action = sps_pkg::ACTION_READ;
            item.sieve_prime = 16'($urandom_range(65535));
            if ($urandom_range(9) == 0) item.word_index = 6'($urandom_range(63));
            else item.word_index = 6'($urandom_range(0, 32'(w_top)));
            send_req(item, 1'b0, '0, pred);
         end
         if ($urandom_range(1)) send_req(random_item(), 1'b0, '0, pred);
         round++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      for (guard = 0; guard < 500000 && results_due.size() != 0; guard++) @(posedge clock);
      if (results_due.size() != 0)
         report_mismatch("transactions left without a result", 64'(results_due.size()),
                         64'd0);
      repeat (50) @(posedge clock);

      $display("Sent %0d transactions (%0d mark, %0d read, %0d clear) over %0d segment setups,",
               items_sent, marks_sent, reads_sent, clears_sent, round);
      $display("with %0d register writes; %0d results checked, %0d mismatches.",
               csr_writes, results_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASS segmented_prime_sieve_core");
      end else begin
         $display("FAIL segmented_prime_sieve_core");
      end
      $finish;
   end

endmodule
